// ----- design/adc_voltmeter_two_digit_display_top_macros.svh -----
// Assertion macros shared by the voltmeter checker.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef ADC_VOLTMETER_TWO_DIGIT_DISPLAY_TOP_MACROS_SVH
`define ADC_VOLTMETER_TWO_DIGIT_DISPLAY_TOP_MACROS_SVH

// Same-cycle implication.
`define AVTD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define AVTD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/avtd_pkg.sv -----
// Package for the averaging voltmeter: constants, queue item type and the
// reading and segment decode functions. Depends on nothing.
package avtd_pkg;

    localparam int SAMPLE_W          = 10;
    localparam int SAMPLES_PER_GROUP = 4;
    localparam int GROUP_SUM_W       = $clog2(1023 * SAMPLES_PER_GROUP + 1);
    localparam int GROUP_CNT_W       = $clog2(SAMPLES_PER_GROUP + 1);
    localparam int DIVIDER_W         = 8;
    localparam int BCD_W             = 8;
    localparam int SEG_W             = 7;
    localparam int DEN_W             = 2;
    localparam int SHOWN_W           = 6;
    localparam int QUEUE_DEPTH       = 4;
    localparam int QPTR_W            = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W            = $clog2(QUEUE_DEPTH + 1);
    localparam logic [DIVIDER_W-1:0] DIVIDER_RESET = 8'd25;

    localparam logic [DEN_W-1:0] DEN_UNITS = 2'd1;
    localparam logic [DEN_W-1:0] DEN_TENS  = 2'd2;

    typedef struct packed {
        logic                is_tick;
        logic [SAMPLE_W-1:0] sample;
    } t_item;

    localparam logic [SEG_W-1:0] SEG_TABLE [16] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07,
        7'h7F, 7'h6F, 7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71
    };

    function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] digit);
        return SEG_TABLE[digit];
    endfunction

    // (avg * 33 + 511) / 1023 equals (avg + 15) / 31; the division by 31 is
    // a multiplication by 2115 / 65536, exact for every 10-bit average.
    function automatic logic [BCD_W-1:0] reading_bcd(input logic [SAMPLE_W-1:0] avg);
        logic [10:0] x;
        logic [22:0] p;
        logic [5:0]  q;
        logic [3:0]  tens;
        logic [5:0]  ones;
        x = {1'b0, avg} + 11'd15;
        p = x * 12'd2115;
        q = p[21:16];
        if (q >= 6'd30) begin
            tens = 4'd3;
            ones = q - 6'd30;
        end else if (q >= 6'd20) begin
            tens = 4'd2;
            ones = q - 6'd20;
        end else if (q >= 6'd10) begin
            tens = 4'd1;
            ones = q - 6'd10;
        end else begin
            tens = 4'd0;
            ones = q;
        end
        return {tens, ones[3:0]};
    endfunction

endpackage

// ----- design/avtd_front.sv -----
// Front part of the voltmeter: accepts input items, tags them as sample or
// tick and holds them in a short in-order queue. Depends on avtd_pkg.
module avtd_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_func,
    input  logic [avtd_pkg::SAMPLE_W-1:0]    i_sample,
    output logic                             o_q_valid,
    input  logic                             i_q_ready,
    output avtd_pkg::t_item                  o_q_item
);

    avtd_pkg::t_item                 r_mem [avtd_pkg::QUEUE_DEPTH];
    logic [avtd_pkg::QPTR_W-1:0]     r_wr_ptr, n_wr_ptr;
    logic [avtd_pkg::QPTR_W-1:0]     r_rd_ptr, n_rd_ptr;
    logic [avtd_pkg::QCNT_W-1:0]     r_count, n_count;
    logic                            w_push, w_pop;
    avtd_pkg::t_item                 w_item;

    assign o_in_ready = (r_count != avtd_pkg::QCNT_W'(avtd_pkg::QUEUE_DEPTH));
    assign o_q_valid  = (r_count != '0);
    assign o_q_item   = r_mem[r_rd_ptr];
    assign w_push     = i_in_valid && o_in_ready;
    assign w_pop      = o_q_valid && i_q_ready;

    always_comb begin
        w_item.is_tick = i_func;
        w_item.sample  = i_sample;
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == avtd_pkg::QPTR_W'(avtd_pkg::QUEUE_DEPTH - 1))
                       ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == avtd_pkg::QPTR_W'(avtd_pkg::QUEUE_DEPTH - 1))
                       ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_push && w_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ----- design/avtd_back.sv -----
// Back part of the voltmeter: averages samples, forms readings on ticks and
// drives the registered display result. Depends on avtd_pkg.
module avtd_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic [avtd_pkg::DIVIDER_W-1:0]     i_cfg_data,
    input  logic                               i_q_valid,
    output logic                               o_q_ready,
    input  avtd_pkg::t_item                    i_q_item,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [avtd_pkg::SEG_W-1:0]         o_segments,
    output logic [avtd_pkg::DEN_W-1:0]         o_digit_enable,
    output logic [avtd_pkg::SHOWN_W-1:0]       o_shown_value
);

    logic [avtd_pkg::DIVIDER_W-1:0]    r_divider;
    logic [avtd_pkg::GROUP_SUM_W-1:0]  r_group_sum, n_group_sum;
    logic [avtd_pkg::GROUP_CNT_W-1:0]  r_group_cnt, n_group_cnt;
    logic [avtd_pkg::SAMPLE_W-1:0]     r_average, n_average;
    logic [avtd_pkg::BCD_W-1:0]        r_shown, n_shown;
    logic [avtd_pkg::DIVIDER_W-1:0]    r_phase, n_phase;
    logic                              r_high_next, n_high_next;
    logic                              r_out_valid, n_out_valid;
    logic [avtd_pkg::SEG_W-1:0]        r_segments, n_segments;
    logic [avtd_pkg::DEN_W-1:0]        r_digit_en, n_digit_en;
    logic [avtd_pkg::SHOWN_W-1:0]      r_shown_out, n_shown_out;
    logic                              w_out_free, w_take;
    logic [avtd_pkg::DIVIDER_W:0]      w_phase_inc;
    logic [avtd_pkg::GROUP_SUM_W-1:0]  w_sum_add;
    logic [avtd_pkg::GROUP_SUM_W-1:0]  w_quot;

    assign w_out_free     = !r_out_valid || i_out_ready;
    assign o_q_ready      = !i_q_item.is_tick || w_out_free;
    assign w_take         = i_q_valid && o_q_ready;
    assign o_out_valid    = r_out_valid;
    assign o_segments     = r_segments;
    assign o_digit_enable = r_digit_en;
    assign o_shown_value  = r_shown_out;
    assign w_phase_inc    = {1'b0, r_phase} + 1'b1;
    assign w_sum_add      = r_group_sum + avtd_pkg::GROUP_SUM_W'(i_q_item.sample);
    assign w_quot         = avtd_pkg::GROUP_SUM_W'(w_sum_add / avtd_pkg::SAMPLES_PER_GROUP);

    always_comb begin
        n_group_sum = r_group_sum;
        n_group_cnt = r_group_cnt;
        n_average   = r_average;
        n_shown     = r_shown;
        n_phase     = r_phase;
        n_high_next = r_high_next;
        n_out_valid = r_out_valid && !i_out_ready;
        n_segments  = r_segments;
        n_digit_en  = r_digit_en;
        n_shown_out = r_shown_out;
        if (w_take && !i_q_item.is_tick) begin
            if (r_group_cnt + 1'b1 >= avtd_pkg::GROUP_CNT_W'(avtd_pkg::SAMPLES_PER_GROUP)) begin
                n_average   = w_quot[avtd_pkg::SAMPLE_W-1:0];
                n_group_sum = '0;
                n_group_cnt = '0;
            end else begin
                n_group_sum = w_sum_add;
                n_group_cnt = r_group_cnt + 1'b1;
            end
        end
        if (w_take && i_q_item.is_tick) begin
            if (r_phase == '0) begin
                n_shown = avtd_pkg::reading_bcd(r_average);
            end
            n_phase = (w_phase_inc >= {1'b0, r_divider})
                      ? '0 : w_phase_inc[avtd_pkg::DIVIDER_W-1:0];
            if (r_high_next) begin
                n_segments = avtd_pkg::seg_of(n_shown[7:4]);
                n_digit_en = avtd_pkg::DEN_TENS;
            end else begin
                n_segments = avtd_pkg::seg_of(n_shown[3:0]);
                n_digit_en = avtd_pkg::DEN_UNITS;
            end
            n_shown_out = n_shown[avtd_pkg::SHOWN_W-1:0];
            n_high_next = !r_high_next;
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_divider   <= avtd_pkg::DIVIDER_RESET;
            r_group_sum <= '0;
            r_group_cnt <= '0;
            r_average   <= '0;
            r_shown     <= '0;
            r_phase     <= '0;
            r_high_next <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_divider <= i_cfg_data;
            end
            r_group_sum <= n_group_sum;
            r_group_cnt <= n_group_cnt;
            r_average   <= n_average;
            r_shown     <= n_shown;
            r_phase     <= n_phase;
            r_high_next <= n_high_next;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_segments  <= n_segments;
        r_digit_en  <= n_digit_en;
        r_shown_out <= n_shown_out;
    end

endmodule

// ----- design/adc_voltmeter_two_digit_display_top.sv -----
// Averaging voltmeter with a two-digit multiplexed 7-segment display. One
// input item, sample or refresh tick, can be taken every cycle. Items pass in
// order through a four-entry queue into a registered execute stage, so a
// tick's display result is in the output register at the earliest from the clock
// edge after its transfer; samples give no result. A stalled result holds the
// oldest tick in the queue, items behind it wait, and the input stalls once all
// four entries are full. Depends on avtd_pkg, avtd_front and avtd_back.
module adc_voltmeter_two_digit_display_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [avtd_pkg::DIVIDER_W-1:0]     i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_func,
    input  logic [avtd_pkg::SAMPLE_W-1:0]      i_sample,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [avtd_pkg::SEG_W-1:0]         o_segments,
    output logic [avtd_pkg::DEN_W-1:0]         o_digit_enable,
    output logic [avtd_pkg::SHOWN_W-1:0]       o_shown_value
);

    logic            w_q_valid;
    logic            w_q_ready;
    avtd_pkg::t_item w_q_item;

    assign o_cfg_ready = 1'b1;

    avtd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_func     (i_func),
        .i_sample   (i_sample),
        .o_q_valid  (w_q_valid),
        .i_q_ready  (w_q_ready),
        .o_q_item   (w_q_item)
    );

    avtd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_q_valid      (w_q_valid),
        .o_q_ready      (w_q_ready),
        .i_q_item       (w_q_item),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_segments     (o_segments),
        .o_digit_enable (o_digit_enable),
        .o_shown_value  (o_shown_value)
    );

endmodule

// ----- design/avtd_checker.sv -----
// Port-level checker for the voltmeter, bound to the top level.
// Depends on avtd_pkg and the assertion macro header.
`include "adc_voltmeter_two_digit_display_top_macros.svh"

module avtd_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input logic [avtd_pkg::SEG_W-1:0]         o_segments,
    input logic [avtd_pkg::DEN_W-1:0]         o_digit_enable,
    input logic [avtd_pkg::SHOWN_W-1:0]       o_shown_value
);

    logic                                                               w_one_digit;
    logic                                                               w_bcd_ok;
    logic [3:0]                                                         w_digit;
    logic [avtd_pkg::SEG_W-1:0]                                         w_want_segs;
    logic [avtd_pkg::SEG_W+avtd_pkg::DEN_W+avtd_pkg::SHOWN_W-1:0]       w_payload;

    assign w_one_digit = (o_digit_enable == avtd_pkg::DEN_UNITS)
                         || (o_digit_enable == avtd_pkg::DEN_TENS);
    assign w_bcd_ok    = (o_shown_value[3:0] <= 4'd9) && (o_shown_value[5:4] <= 2'd3);
    assign w_digit     = (o_digit_enable == avtd_pkg::DEN_TENS)
                         ? {2'b00, o_shown_value[5:4]} : o_shown_value[3:0];
    assign w_want_segs = avtd_pkg::seg_of(w_digit);
    assign w_payload   = {o_segments, o_digit_enable, o_shown_value};

    `AVTD_ASSERT_IMP(a_digit_enable, o_out_valid, w_one_digit, "digit enable is not one digit")
    `AVTD_ASSERT_IMP(a_bcd_range, o_out_valid, w_bcd_ok, "shown reading is not valid BCD")
    `AVTD_ASSERT_IMP(a_segments_match, o_out_valid, o_segments == w_want_segs, "bad segments")
    `AVTD_ASSERT_NEXT(a_stall_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(w_payload), "stalled result changed")

endmodule

bind adc_voltmeter_two_digit_display_top avtd_checker u_avtd_checker (.*);
